/* rtl/core/cjt_pkg.sv */
// Shared types and constants of the compacting job table.
// Used by every module of the block; depends on nothing.
package cjt_pkg;

    localparam int TABLE_DEPTH   = 16;
    localparam int PROCS_PER_JOB = 8;

    localparam int ROW_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int SLOT_W = (PROCS_PER_JOB > 1) ? $clog2(PROCS_PER_JOB) : 1;
    localparam int FILL_W = $clog2(PROCS_PER_JOB + 1);

    localparam int ID_W   = 16;
    localparam int GRP_W  = 22;
    localparam int PID_W  = 22;
    localparam int ST_W   = 2;
    localparam int NUM_W  = 4;
    localparam int REQ_W  = 3;
    localparam int STS_W  = 3;

    localparam logic [ID_W-1:0] ID_MAX      = '1;
    localparam logic [ST_W-1:0] STATE_FORE  = '0;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD  = 3'd0,
        REQ_DEL  = 3'd1,
        REQ_FIND = 3'd2,
        REQ_FG   = 3'd3,
        REQ_RMV  = 3'd4
    } req_kind_t;

    typedef enum logic [STS_W-1:0] {
        STS_OK        = 3'd0,
        STS_NOT_FOUND = 3'd1,
        STS_FULL      = 3'd2,
        STS_TOO_MANY  = 3'd3,
        STS_ID_EXH    = 3'd4
    } status_t;

    typedef enum logic {
        BK_IDLE,
        BK_EXEC
    } back_state_t;

    typedef struct packed {
        req_kind_t          kind;
        logic [ID_W-1:0]    job;
        logic [GRP_W-1:0]   group;
        logic [ST_W-1:0]    state;
        logic [PID_W-1:0]   pid;
        logic               last;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [ID_W-1:0]    job;
        logic [GRP_W-1:0]   group;
        logic [ST_W-1:0]    state;
        logic [NUM_W-1:0]   remaining;
        logic [NUM_W-1:0]   total;
    } rsp_t;

    typedef struct packed {
        logic [CNT_W-1:0]   entry_count;
        logic               busy;
    } stat_t;

endpackage

/* rtl/core/compacting_job_table_unit.sv */
// Top level of the compacting job table: request queue front end and table
// back end. Depends on cjt_pkg, cjt_front and cjt_back.
//
// Channel   Direction  Transaction
// s_axis    in         one request item (add item, delete, find, find foreground, remove)
// m_axis    out        one result per request, none for a non-final add item or an unknown kind
//
// In the back end, the idle state looks up the row as it takes a request, and the
// execute state updates the table and loads the result register.
// The front end queues two requests, so input is taken while the back end works.
// A stalled result holds the back end in its execute state until it is taken.
// Reset empties the table, the queue and any add run in progress.
module compacting_job_table_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,   // req_type
    input  logic [63:0] s_tdata,   // job_number, group_id, state_code, proc_id, zeros
    input  logic        s_tlast,   // proc_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [2:0]  m_tuser,   // status
    output logic [47:0] m_tdata    // job_out, group_out, state_out, remaining_out, total_out
);

    logic           q_valid;
    logic           q_pop;
    cjt_pkg::req_t  q_req;
    cjt_pkg::rsp_t  rsp;
    cjt_pkg::stat_t stat;

    cjt_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_req    (q_req),
        .q_pop    (q_pop)
    );

    cjt_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_req     (q_req),
        .q_pop     (q_pop),
        .rsp_valid (m_tvalid),
        .rsp_ready (m_tready),
        .rsp       (rsp),
        .stat      (stat)
    );

    assign m_tuser = rsp.status;
    assign m_tdata = {rsp.total, rsp.remaining, rsp.state, rsp.group, rsp.job};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.entry_count <= cjt_pkg::CNT_W'(cjt_pkg::TABLE_DEPTH))
        else $error("job table count beyond depth");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("back end took from an empty queue");

    a_pop_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> !q_pop && stat.busy)
        else $error("back end took a request while busy");

endmodule

/* rtl/core/cjt_front.sv */
// Front end of the compacting job table: takes requests, drops unknown kinds
// and holds up to two requests for the back end. Depends on cjt_pkg.
module cjt_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [2:0]          s_tuser,  // req_type
    input  logic [63:0]         s_tdata,  // job_number, group_id, state_code, proc_id, zeros
    input  logic                s_tlast,  // proc_last
    output logic                q_valid,
    output cjt_pkg::req_t       q_req,
    input  logic                q_pop
);

    cjt_pkg::req_t  slot0_reg, slot0_next;
    cjt_pkg::req_t  slot1_reg, slot1_next;
    logic [1:0]     cnt_reg, cnt_next;
    cjt_pkg::req_t  in_req;
    logic           known;
    logic           push;
    logic           pop;

    always_comb
    begin
        in_req.kind  = cjt_pkg::req_kind_t'(s_tuser);
        in_req.job   = s_tdata[15:0];
        in_req.group = s_tdata[37:16];
        in_req.state = s_tdata[39:38];
        in_req.pid   = s_tdata[61:40];
        in_req.last  = s_tlast;
    end

    assign known    = s_tuser <= 3'(cjt_pkg::REQ_RMV);
    assign s_tready = cnt_reg != 2'd2;
    assign push     = s_tvalid && s_tready && known;
    assign pop      = q_pop && (cnt_reg != 2'd0);
    assign q_valid  = cnt_reg != 2'd0;
    assign q_req    = slot0_reg;

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_reg;
        if (pop)
        begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
        if (push)
        begin
            if (cnt_next == 2'd0)
            begin
                slot0_next = in_req;
            end
            else
            begin
                slot1_next = in_req;
            end
            cnt_next = cnt_next + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

/* rtl/core/cjt_back.sv */
// Back end of the compacting job table: holds the job rows, looks up, appends,
// deletes with compaction and removes processes. Depends on cjt_pkg.
module cjt_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  cjt_pkg::req_t       q_req,
    output logic                q_pop,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output cjt_pkg::rsp_t       rsp,
    output cjt_pkg::stat_t      stat
);

    localparam int D = cjt_pkg::TABLE_DEPTH;
    localparam int P = cjt_pkg::PROCS_PER_JOB;

    logic [cjt_pkg::ID_W-1:0]   ids_reg [D], ids_next [D];
    logic [cjt_pkg::GRP_W-1:0]  grp_reg [D], grp_next [D];
    logic [cjt_pkg::ST_W-1:0]   st_reg [D], st_next [D];
    logic [cjt_pkg::FILL_W-1:0] tot_reg [D], tot_next [D];
    logic [cjt_pkg::FILL_W-1:0] rem_reg [D], rem_next [D];
    logic [cjt_pkg::ROW_W-1:0]  phys_reg [D], phys_next [D];

    // Process ids live in one memory word per physical block; rows point at blocks.
    logic [P-1:0][cjt_pkg::PID_W-1:0] procs_mem [D];
    logic [P-1:0][cjt_pkg::PID_W-1:0] rd_word_reg;
    logic                             mem_we;
    logic [cjt_pkg::ROW_W-1:0]        mem_addr;
    logic [cjt_pkg::SLOT_W-1:0]       mem_slot;
    logic [cjt_pkg::PID_W-1:0]        mem_data;
    logic [cjt_pkg::ROW_W-1:0]        rd_addr;

    logic [cjt_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [cjt_pkg::FILL_W-1:0] fill_reg, fill_next;
    logic                       ovf_reg, ovf_next;
    cjt_pkg::back_state_t       state_reg, state_next;
    cjt_pkg::req_t              cur_reg, cur_next;
    logic [cjt_pkg::ROW_W-1:0]  row_reg, row_next;
    logic                       hit_reg, hit_next;
    logic                       out_valid_reg, out_valid_next;
    cjt_pkg::rsp_t              out_reg, out_next;

    logic                       need_out;
    logic                       fill_ok;
    logic [cjt_pkg::FILL_W-1:0] n_items;
    logic [cjt_pkg::ID_W-1:0]   max_id;
    logic [cjt_pkg::ROW_W-1:0]  wr_row;
    logic [cjt_pkg::ROW_W-1:0]  last_row;
    logic                       slot_hit;
    logic [cjt_pkg::SLOT_W-1:0] slot_idx;
    logic [cjt_pkg::FILL_W-1:0] rem_dec;
    cjt_pkg::rsp_t              row_rsp;
    cjt_pkg::rsp_t              none_rsp;

    assign rsp_valid        = out_valid_reg;
    assign rsp              = out_reg;
    assign stat.entry_count = count_reg;
    assign stat.busy        = state_reg == cjt_pkg::BK_EXEC;

    assign wr_row   = count_reg[cjt_pkg::ROW_W-1:0];
    assign last_row = cjt_pkg::ROW_W'(count_reg - cjt_pkg::CNT_W'(1));
    assign max_id   = (count_reg == '0) ? '0 : ids_reg[last_row];
    assign fill_ok  = fill_reg < cjt_pkg::FILL_W'(P);
    assign n_items  = fill_ok ? fill_reg + cjt_pkg::FILL_W'(1) : fill_reg;
    assign need_out = !(cur_reg.kind == cjt_pkg::REQ_ADD && !cur_reg.last);
    assign rem_dec  = (rem_reg[row_reg] != '0) ? rem_reg[row_reg] - cjt_pkg::FILL_W'(1)
                                               : rem_reg[row_reg];
    assign rd_addr  = phys_reg[row_next];

    always_comb
    begin
        slot_hit = 1'b0;
        slot_idx = '0;
        for (int j = P - 1; j >= 0; j--)
        begin
            if (cjt_pkg::FILL_W'(j) < tot_reg[row_reg] && cur_reg.pid != '0
                && rd_word_reg[j] == cur_reg.pid)
            begin
                slot_hit = 1'b1;
                slot_idx = cjt_pkg::SLOT_W'(j);
            end
        end
    end

    always_comb
    begin
        none_rsp           = '0;
        none_rsp.status    = cjt_pkg::STS_NOT_FOUND;
        row_rsp.status     = cjt_pkg::STS_OK;
        row_rsp.job        = ids_reg[row_reg];
        row_rsp.group      = grp_reg[row_reg];
        row_rsp.state      = st_reg[row_reg];
        row_rsp.remaining  = cjt_pkg::NUM_W'(rem_reg[row_reg]);
        row_rsp.total      = cjt_pkg::NUM_W'(tot_reg[row_reg]);
    end

    always_comb
    begin
        ids_next       = ids_reg;
        grp_next       = grp_reg;
        st_next        = st_reg;
        tot_next       = tot_reg;
        rem_next       = rem_reg;
        phys_next      = phys_reg;
        count_next     = count_reg;
        fill_next      = fill_reg;
        ovf_next       = ovf_reg;
        state_next     = state_reg;
        cur_next       = cur_reg;
        row_next       = row_reg;
        hit_next       = hit_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_addr       = '0;
        mem_slot       = '0;
        mem_data       = '0;

        case (state_reg)
            cjt_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cur_next   = q_req;
                    state_next = cjt_pkg::BK_EXEC;
                    hit_next   = 1'b0;
                    row_next   = '0;
                    for (int i = D - 1; i >= 0; i--)
                    begin
                        if (cjt_pkg::CNT_W'(i) < count_reg
                            && ((q_req.kind == cjt_pkg::REQ_FG) ? st_reg[i] == cjt_pkg::STATE_FORE
                                                                : ids_reg[i] == q_req.job))
                        begin
                            hit_next = 1'b1;
                            row_next = cjt_pkg::ROW_W'(i);
                        end
                    end
                end
            end
            cjt_pkg::BK_EXEC:
            begin
                if (!(need_out && out_valid_reg && !rsp_ready))
                begin
                    state_next = cjt_pkg::BK_IDLE;
                    if (need_out)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = none_rsp;
                    end
                    fill_next = '0;
                    ovf_next  = 1'b0;
                    case (cur_reg.kind)
                        cjt_pkg::REQ_ADD:
                        begin
                            if (fill_ok)
                            begin
                                if (count_reg < cjt_pkg::CNT_W'(D))
                                begin
                                    mem_we   = 1'b1;
                                    mem_addr = phys_reg[wr_row];
                                    mem_slot = fill_reg[cjt_pkg::SLOT_W-1:0];
                                    mem_data = cur_reg.pid;
                                end
                                fill_next = fill_reg + cjt_pkg::FILL_W'(1);
                                ovf_next  = ovf_reg;
                            end
                            else
                            begin
                                fill_next = fill_reg;
                                ovf_next  = 1'b1;
                            end
                            if (cur_reg.last)
                            begin
                                fill_next = '0;
                                ovf_next  = 1'b0;
                                out_next  = '0;
                                if (count_reg >= cjt_pkg::CNT_W'(D))
                                begin
                                    out_next.status = cjt_pkg::STS_FULL;
                                end
                                else if (ovf_reg || !fill_ok)
                                begin
                                    out_next.status = cjt_pkg::STS_TOO_MANY;
                                end
                                else if (max_id == cjt_pkg::ID_MAX)
                                begin
                                    out_next.status = cjt_pkg::STS_ID_EXH;
                                end
                                else
                                begin
                                    ids_next[wr_row] = max_id + cjt_pkg::ID_W'(1);
                                    grp_next[wr_row] = cur_reg.group;
                                    st_next[wr_row]  = cur_reg.state;
                                    tot_next[wr_row] = n_items;
                                    rem_next[wr_row] = n_items;
                                    count_next       = count_reg + cjt_pkg::CNT_W'(1);
                                    out_next.status    = cjt_pkg::STS_OK;
                                    out_next.job       = max_id + cjt_pkg::ID_W'(1);
                                    out_next.group     = cur_reg.group;
                                    out_next.state     = cur_reg.state;
                                    out_next.remaining = cjt_pkg::NUM_W'(n_items);
                                    out_next.total     = cjt_pkg::NUM_W'(n_items);
                                end
                            end
                        end
                        cjt_pkg::REQ_FIND, cjt_pkg::REQ_FG:
                        begin
                            if (hit_reg)
                            begin
                                out_next = row_rsp;
                            end
                        end
                        cjt_pkg::REQ_DEL:
                        begin
                            if (hit_reg)
                            begin
                                out_next   = row_rsp;
                                count_next = count_reg - cjt_pkg::CNT_W'(1);
                                for (int i = 0; i < D - 1; i++)
                                begin
                                    if (cjt_pkg::ROW_W'(i) >= row_reg
                                        && cjt_pkg::CNT_W'(i + 1) < count_reg)
                                    begin
                                        ids_next[i]  = ids_reg[i + 1];
                                        grp_next[i]  = grp_reg[i + 1];
                                        st_next[i]   = st_reg[i + 1];
                                        tot_next[i]  = tot_reg[i + 1];
                                        rem_next[i]  = rem_reg[i + 1];
                                        phys_next[i] = phys_reg[i + 1];
                                    end
                                end
                                phys_next[last_row] = phys_reg[row_reg];
                            end
                        end
                        cjt_pkg::REQ_RMV:
                        begin
                            if (hit_reg && slot_hit)
                            begin
                                mem_we             = 1'b1;
                                mem_addr           = phys_reg[row_reg];
                                mem_slot           = slot_idx;
                                mem_data           = '0;
                                rem_next[row_reg]  = rem_dec;
                                out_next           = row_rsp;
                                out_next.remaining = cjt_pkg::NUM_W'(rem_dec);
                            end
                        end
                        default:
                        begin
                            fill_next = fill_reg;
                            ovf_next  = ovf_reg;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = cjt_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cjt_pkg::BK_IDLE;
            count_reg     <= '0;
            fill_reg      <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < D; i++)
            begin
                phys_reg[i] <= cjt_pkg::ROW_W'(i);
            end
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            fill_reg      <= fill_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            phys_reg      <= phys_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            procs_mem[mem_addr][mem_slot] <= mem_data;
        end
        rd_word_reg <= procs_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        ids_reg   <= ids_next;
        grp_reg   <= grp_next;
        st_reg    <= st_next;
        tot_reg   <= tot_next;
        rem_reg   <= rem_next;
        cur_reg   <= cur_next;
        row_reg   <= row_next;
        hit_reg   <= hit_next;
        out_reg   <= out_next;
    end

endmodule

/* tb/sv/compacting_job_table_unit_tb.sv */
// Testbench of the compacting job table: directed and random request streams with
// random idling, checked against a job table predictor in a small scoreboard class.
// Depends on cjt_pkg and compacting_job_table_unit.
import cjt_pkg::*;

class job_table_scoreboard;
    logic [ID_W-1:0]  ids [TABLE_DEPTH];
    logic [GRP_W-1:0] groups [TABLE_DEPTH];
    logic [ST_W-1:0]  states [TABLE_DEPTH];
    int               totals [TABLE_DEPTH];
    int               remaining [TABLE_DEPTH];
    logic [PID_W-1:0] procs [TABLE_DEPTH][PROCS_PER_JOB];
    int               count;
    int               fill;
    bit               overflow;
    rsp_t             pending [$];
    int               errors;
    int               results_seen;

    function void clear();
        count = 0;
        fill = 0;
        overflow = 0;
        errors = 0;
        results_seen = 0;
        pending.delete();
    endfunction

    function rsp_t row_result(status_t s, int r, bit have);
        rsp_t o;
        o = '0;
        o.status = s;
        if (have)
        begin
            o.job = ids[r];
            o.group = groups[r];
            o.state = states[r];
            o.remaining = NUM_W'(remaining[r]);
            o.total = NUM_W'(totals[r]);
        end
        return o;
    endfunction

    function int row_of(logic [ID_W-1:0] id);
        for (int i = 0; i < count; i++)
            if (ids[i] == id)
                return i;
        return -1;
    endfunction

    function void note_request(req_t q);
        int r;
        int n;
        int maxid;
        bit done;
        if (q.kind == REQ_ADD)
        begin
            if (fill < PROCS_PER_JOB)
            begin
                if (count < TABLE_DEPTH)
                    procs[count][fill] = q.pid;
                fill++;
            end
            else
                overflow = 1;
            if (!q.last)
                return;
            n = fill;
            fill = 0;
            if (count >= TABLE_DEPTH)
            begin
                overflow = 0;
                pending.push_back(row_result(STS_FULL, 0, 0));
                return;
            end
            if (overflow)
            begin
                overflow = 0;
                pending.push_back(row_result(STS_TOO_MANY, 0, 0));
                return;
            end
            maxid = 0;
            for (int i = 0; i < count; i++)
                if (ids[i] > maxid)
                    maxid = ids[i];
            if (maxid >= ID_MAX)
            begin
                pending.push_back(row_result(STS_ID_EXH, 0, 0));
                return;
            end
            ids[count] = ID_W'(maxid + 1);
            groups[count] = q.group;
            states[count] = q.state;
            totals[count] = n;
            remaining[count] = n;
            count++;
            pending.push_back(row_result(STS_OK, count - 1, 1));
            return;
        end
        if (q.kind > REQ_RMV)
            return;
        fill = 0;
        overflow = 0;
        if (q.kind == REQ_FG)
        begin
            for (int i = 0; i < count; i++)
                if (states[i] == STATE_FORE)
                begin
                    pending.push_back(row_result(STS_OK, i, 1));
                    return;
                end
            pending.push_back(row_result(STS_NOT_FOUND, 0, 0));
            return;
        end
        r = row_of(q.job);
        if (r < 0)
        begin
            pending.push_back(row_result(STS_NOT_FOUND, 0, 0));
            return;
        end
        if (q.kind == REQ_FIND)
            pending.push_back(row_result(STS_OK, r, 1));
        else if (q.kind == REQ_DEL)
        begin
            pending.push_back(row_result(STS_OK, r, 1));
            for (int i = r; i + 1 < count; i++)
            begin
                ids[i] = ids[i + 1];
                groups[i] = groups[i + 1];
                states[i] = states[i + 1];
                totals[i] = totals[i + 1];
                remaining[i] = remaining[i + 1];
                procs[i] = procs[i + 1];
            end
            count--;
        end
        else
        begin
            done = 0;
            if (q.pid != 0)
                for (int i = 0; i < totals[r] && !done; i++)
                    if (procs[r][i] == q.pid)
                    begin
                        procs[r][i] = '0;
                        if (remaining[r] > 0)
                            remaining[r]--;
                        pending.push_back(row_result(STS_OK, r, 1));
                        done = 1;
                    end
            if (!done)
                pending.push_back(row_result(STS_NOT_FOUND, 0, 0));
        end
    endfunction

    function void check_result(rsp_t got);
        rsp_t want;
        results_seen++;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.status !== want.status)
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        if (got.job !== want.job)
            $display("%0t: job expected %0d actual %0d", $time, want.job, got.job);
        if (got.group !== want.group)
            $display("%0t: group expected %h actual %h", $time, want.group, got.group);
        if (got.state !== want.state)
            $display("%0t: state expected %0d actual %0d", $time, want.state, got.state);
        if (got.remaining !== want.remaining)
            $display("%0t: remaining expected %0d actual %0d", $time, want.remaining,
                     got.remaining);
        if (got.total !== want.total)
            $display("%0t: total expected %0d actual %0d", $time, want.total, got.total);
        if (got !== want)
            errors++;
    endfunction
endclass

module compacting_job_table_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [2:0]  s_tuser;
    logic [63:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [2:0]  m_tuser;
    logic [47:0] m_tdata;

    job_table_scoreboard board;
    int  cycles;
    bit  sending_done;
    bit  hold_off;
    bit  calm;
    int  items_sent;

    compacting_job_table_unit dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser(s_tuser),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tuser(m_tuser),
        .m_tdata(m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [PID_W-1:0] random_pid();
        case ($urandom_range(0, 3))
            0: return PID_W'(1);
            1: return {PID_W{1'b1}};
            default: return PID_W'($urandom_range(1, 40));
        endcase
    endfunction

    function automatic rsp_t unpack_result(logic [2:0] u, logic [47:0] d);
        rsp_t o;
        o.status = status_t'(u);
        o.job = d[15:0];
        o.group = d[37:16];
        o.state = d[39:38];
        o.remaining = d[43:40];
        o.total = d[47:44];
        return o;
    endfunction

    task automatic send_request(req_t q);
        if (!calm)
            while ($urandom_range(0, 99) < 24)
            begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
        s_tvalid <= 1'b1;
        s_tuser <= q.kind;
        s_tdata <= {2'b0, q.pid, q.state, q.group, q.job};
        s_tlast <= q.last;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_request(q);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_plain(logic [2:0] kind, logic [ID_W-1:0] job, logic [PID_W-1:0] pid);
        req_t q;
        q = '0;
        q.kind = req_kind_t'(kind);
        q.job = job;
        q.pid = pid;
        q.group = GRP_W'($urandom);
        q.state = ST_W'($urandom);
        q.last = 1'($urandom);
        send_request(q);
    endtask

    task automatic send_add(int n, logic [GRP_W-1:0] grp, logic [ST_W-1:0] st);
        req_t q;
        for (int i = 0; i < n; i++)
        begin
            q = '0;
            q.kind = REQ_ADD;
            q.pid = random_pid();
            q.job = ID_W'($urandom);
            q.group = (i == n - 1) ? grp : GRP_W'($urandom);
            q.state = (i == n - 1) ? st : ST_W'($urandom);
            q.last = (i == n - 1);
            send_request(q);
        end
    endtask

    function automatic logic [ID_W-1:0] pick_job();
        if (board.count > 0 && $urandom_range(0, 4) != 0)
            return board.ids[$urandom_range(0, board.count - 1)];
        return $urandom_range(0, 3) == 0 ? ID_W'($urandom) : ID_W'($urandom_range(0, 30));
    endfunction

    function automatic logic [PID_W-1:0] pick_pid(logic [ID_W-1:0] job);
        int r;
        r = board.row_of(job);
        if (r >= 0 && board.totals[r] > 0 && $urandom_range(0, 3) != 0)
            return board.procs[r][$urandom_range(0, board.totals[r] - 1)];
        return $urandom_range(0, 5) == 0 ? PID_W'(0) : random_pid();
    endfunction

    initial
    begin
        logic [ID_W-1:0] j;
        board = new();
        board.clear();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = '0;
        s_tdata = '0;
        s_tlast = 1'b0;
        sending_done = 0;
        calm = 0;
        items_sent = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_plain(REQ_FG, 0, 1);
        send_plain(REQ_FIND, 0, 1);
        send_plain(REQ_DEL, ID_MAX, 1);
        send_add(1, '1, 2'd3);
        send_add(PROCS_PER_JOB, '0, STATE_FORE);
        send_add(PROCS_PER_JOB + 2, 22'h155555, 2'd1);
        send_plain(REQ_FIND, 2, 0);
        send_plain(REQ_FG, 0, 0);
        send_plain(REQ_RMV, 2, 0);
        send_plain(REQ_RMV, 1, board.procs[0][0]);
        send_plain(REQ_RMV, 1, board.procs[0][0]);
        send_plain(3'd5, 0, 0);
        send_plain(3'd7, '1, '1);
        send_add(2, 22'h2aaaaa, 2'd2);
        send_plain(REQ_DEL, 1, 0);
        send_plain(REQ_FIND, 3, 0);
        send_add(3, 5, 0);
        send_plain(REQ_ADD, 0, 5);
        send_plain(REQ_FIND, 2, 0);

        while (items_sent < 1000)
        begin
            calm = (items_sent > 400 && items_sent < 520);
            case ($urandom_range(0, 11))
                0, 1, 2, 3:
                    send_add($urandom_range(0, 9) == 0 ? $urandom_range(9, 11)
                             : $urandom_range(1, PROCS_PER_JOB),
                             GRP_W'($urandom), ST_W'($urandom));
                4: send_plain(REQ_DEL, pick_job(), 0);
                5: send_plain(REQ_FIND, pick_job(), 0);
                6: send_plain(REQ_FG, ID_W'($urandom), PID_W'($urandom));
                7, 8:
                begin
                    j = pick_job();
                    send_plain(REQ_RMV, j, pick_pid(j));
                end
                9: send_plain(3'($urandom_range(5, 7)), ID_W'($urandom), PID_W'($urandom));
                10: send_plain(REQ_ADD, ID_W'($urandom), random_pid());
                default:
                begin
                    // Fill the table up so that table full is reached now and then.
                    repeat ($urandom_range(1, 6))
                        send_add($urandom_range(1, 3), GRP_W'($urandom), ST_W'($urandom));
                end
            endcase
        end
        s_tvalid <= 1'b0;
        sending_done = 1;
    end

    initial
    begin
        m_tready = 1'b0;
        hold_off = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (items_sent == 200 && !hold_off)
            begin
                hold_off = 1;
                m_tready <= 1'b0;
                repeat (300) @(negedge clk);
            end
            m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 24);
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            board.check_result(unpack_result(m_tuser, m_tdata));

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
            if (sending_done && board.pending.size() == 0)
            begin
                repeat (20) @(posedge clk);
                if (board.errors == 0 && board.pending.size() == 0)
                    $display("simulation ok");
                else
                    $display("simulation failed");
                $finish;
            end
        end
    end
endmodule
